### rtl/gmtd_pkg.sv
// Shared constants, codes and types of the grid minimum-time search unit.
package gmtd_pkg;

	localparam int MAX_ROWS  = 32;
	localparam int MAX_COLS  = 32;
	localparam int TIME_BITS = 16;
	localparam int CELLS     = MAX_ROWS * MAX_COLS;
	localparam int ADDR_W    = $clog2(CELLS);
	localparam int CNT_W     = $clog2(CELLS + 1);
	localparam int ROW_W     = $clog2(MAX_ROWS);
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int DIM_W     = 6;
	localparam int CFG_IDX_W = 1;
	localparam int DIST_W    = 17;
	localparam logic [DIST_W-1:0] DIST_MAX = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROWS = 1'b0,
		REG_COLS = 1'b1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_LOAD,
		S_CHK1,
		S_CHK2,
		S_CHK3,
		S_CLEAR,
		S_START,
		S_SCAN,
		S_SCAN_END,
		S_PICK,
		S_NREAD,
		S_NWRITE,
		S_EMIT_OK,
		S_EMIT_UNR
	} ctrl_state_t;

	typedef enum logic [3:0] {
		DP_IDLE,
		DP_CHK1,
		DP_CHK2,
		DP_CLEAR,
		DP_START,
		DP_SCAN,
		DP_MARK,
		DP_NREAD,
		DP_NWRITE,
		DP_EMIT_OK,
		DP_EMIT_UNR
	} dp_op_t;

	typedef struct packed {
		logic chk_block;
		logic clear_last;
		logic scan_last;
		logic pick_none;
		logic pick_target;
		logic nbr_last;
		logic out_free;
	} dp_sts_t;

	typedef struct packed {
		logic              visited;
		logic              reached;
		logic [DIST_W-1:0] t_arr;
	} node_t;

endpackage

### rtl/gmtd_if.sv
// Valid/ready channel interfaces for grid cells in and search results out.
interface gmtd_in_if;
	logic                             valid;
	logic                             ready;
	logic [gmtd_pkg::TIME_BITS-1:0]   cell_time;
	logic                             last_cell;
	modport source (output valid, cell_time, last_cell, input ready);
	modport sink (input valid, cell_time, last_cell, output ready);
endinterface

interface gmtd_out_if;
	logic                          valid;
	logic                          ready;
	logic [gmtd_pkg::DIST_W-1:0]   min_time;
	logic                          unreachable;
	modport source (output valid, min_time, unreachable, input ready);
	modport sink (input valid, min_time, unreachable, output ready);
endinterface

### rtl/gmtd_datapath.sv
// Datapath: configuration, cell store, node store, scan and relaxation logic, result register.
module gmtd_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [gmtd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [gmtd_pkg::DIM_W-1:0]          cfg_data,
	input  logic                                load_en,
	input  logic [gmtd_pkg::TIME_BITS-1:0]      cell_time,
	input  logic                                last_cell,
	input  gmtd_pkg::dp_op_t                    op,
	output gmtd_pkg::dp_sts_t                   sts,
	input  logic                                rsp_ready,
	output logic                                rsp_valid,
	output logic [gmtd_pkg::DIST_W-1:0]         min_time,
	output logic                                unreachable
);

	localparam int AW = gmtd_pkg::ADDR_W;
	localparam int CW = gmtd_pkg::CNT_W;
	localparam int DW = gmtd_pkg::DIM_W;
	localparam int TW = gmtd_pkg::DIST_W;

	logic [DW-1:0] rows_q, cols_q, nr, nc;
	logic [2*DW-1:0] prod;
	logic [CW-1:0] n_cells, target, ld_q, cnt_q;
	logic [gmtd_pkg::ROW_W-1:0] r_q, scan_r_s1, best_r_q;
	logic [gmtd_pkg::COL_W-1:0] c_q, scan_c_s1, best_c_q;

	logic [gmtd_pkg::TIME_BITS-1:0] cell_mem [gmtd_pkg::CELLS];
	gmtd_pkg::node_t node_mem [gmtd_pkg::CELLS];
	logic [gmtd_pkg::TIME_BITS-1:0] cell_rd_q;
	gmtd_pkg::node_t node_rd_q, node_wd;
	logic [AW-1:0] cell_ra, node_ra, node_wa;
	logic node_we;

	logic scan_vld_s1;
	logic [AW-1:0] scan_idx_s1;
	logic best_found_q;
	logic [AW-1:0] best_idx_q;
	logic [TW-1:0] best_dist_q;
	logic chk_a_q;

	logic [1:0] k_q;
	logic nbr_ok;
	logic [AW-1:0] nbr_idx, nbr_idx_s1;
	logic nbr_vld_s1;
	logic [TW:0] t1, open_w, arr_w;
	logic [TW-1:0] arr;
	logic better;

	logic out_valid_q, out_unr_q;
	logic [TW-1:0] out_time_q;

	always_comb begin
		if (rows_q < DW'(2)) begin
			nr = DW'(2);
		end else if (rows_q > DW'(gmtd_pkg::MAX_ROWS)) begin
			nr = DW'(gmtd_pkg::MAX_ROWS);
		end else begin
			nr = rows_q;
		end
		if (cols_q < DW'(2)) begin
			nc = DW'(2);
		end else if (cols_q > DW'(gmtd_pkg::MAX_COLS)) begin
			nc = DW'(gmtd_pkg::MAX_COLS);
		end else begin
			nc = cols_q;
		end
	end

	assign prod    = {{DW{1'b0}}, nr} * {{DW{1'b0}}, nc};
	assign n_cells = prod[CW-1:0];
	assign target  = n_cells - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DW'(32);
			cols_q <= DW'(32);
		end else if (cfg_we) begin
			if (cfg_index == gmtd_pkg::REG_ROWS) begin
				rows_q <= cfg_data;
			end else begin
				cols_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ld_q <= '0;
		end else if (load_en) begin
			if (last_cell) begin
				ld_q <= '0;
			end else if (ld_q < n_cells) begin
				ld_q <= ld_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_en && (ld_q < n_cells)) begin
			cell_mem[ld_q[AW-1:0]] <= cell_time;
		end
		cell_rd_q <= cell_mem[cell_ra];
	end

	always_comb begin
		case (k_q)
			2'd0: begin
				nbr_ok  = (DW'(best_c_q) + DW'(1)) < nc;
				nbr_idx = best_idx_q + AW'(1);
			end
			2'd1: begin
				nbr_ok  = best_c_q != '0;
				nbr_idx = best_idx_q - AW'(1);
			end
			2'd2: begin
				nbr_ok  = (DW'(best_r_q) + DW'(1)) < nr;
				nbr_idx = best_idx_q + AW'(nc);
			end
			default: begin
				nbr_ok  = best_r_q != '0;
				nbr_idx = best_idx_q - AW'(nc);
			end
		endcase
	end

	assign t1     = {1'b0, best_dist_q} + (TW+1)'(1);
	assign open_w = (TW+1)'(cell_rd_q);
	always_comb begin
		if (open_w <= t1) begin
			arr_w = t1;
		end else if (cell_rd_q[0] ^ best_dist_q[0]) begin
			arr_w = open_w;
		end else begin
			arr_w = open_w + (TW+1)'(1);
		end
	end
	assign arr    = arr_w[TW] ? gmtd_pkg::DIST_MAX : arr_w[TW-1:0];
	assign better = !node_rd_q.reached || (arr < node_rd_q.t_arr);

	always_comb begin
		case (op)
			gmtd_pkg::DP_CHK1:  cell_ra = AW'(1);
			gmtd_pkg::DP_CHK2:  cell_ra = AW'(nc);
			default:            cell_ra = nbr_idx;
		endcase
		node_ra = (op == gmtd_pkg::DP_SCAN) ? cnt_q[AW-1:0] : nbr_idx;
		node_we = 1'b0;
		node_wa = nbr_idx_s1;
		node_wd = '0;
		case (op)
			gmtd_pkg::DP_CLEAR: begin
				node_we = 1'b1;
				node_wa = cnt_q[AW-1:0];
			end
			gmtd_pkg::DP_START: begin
				node_we = 1'b1;
				node_wa = '0;
				node_wd.reached = 1'b1;
			end
			gmtd_pkg::DP_MARK: begin
				node_we = 1'b1;
				node_wa = best_idx_q;
				node_wd = '{visited: 1'b1, reached: 1'b1, t_arr: best_dist_q};
			end
			gmtd_pkg::DP_NWRITE: begin
				node_we = nbr_vld_s1 && better;
				node_wd = '{visited: node_rd_q.visited, reached: 1'b1, t_arr: arr};
			end
			default: begin
				node_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (node_we) begin
			node_mem[node_wa] <= node_wd;
		end
		node_rd_q <= node_mem[node_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			r_q          <= '0;
			c_q          <= '0;
			scan_vld_s1  <= 1'b0;
			best_found_q <= 1'b0;
			k_q          <= '0;
			nbr_vld_s1   <= 1'b0;
			chk_a_q      <= 1'b0;
		end else begin
			scan_vld_s1 <= op == gmtd_pkg::DP_SCAN;
			nbr_vld_s1  <= (op == gmtd_pkg::DP_NREAD) && nbr_ok;
			case (op)
				gmtd_pkg::DP_CHK1: begin
					cnt_q <= '0;
				end
				gmtd_pkg::DP_CHK2: begin
					chk_a_q <= cell_rd_q > gmtd_pkg::TIME_BITS'(1);
				end
				gmtd_pkg::DP_CLEAR: begin
					cnt_q <= cnt_q + CW'(1);
				end
				gmtd_pkg::DP_START, gmtd_pkg::DP_MARK: begin
					cnt_q <= '0;
					r_q   <= '0;
					c_q   <= '0;
					k_q   <= '0;
				end
				gmtd_pkg::DP_SCAN: begin
					cnt_q <= cnt_q + CW'(1);
					if ((DW'(c_q) + DW'(1)) == nc) begin
						c_q <= '0;
						r_q <= r_q + gmtd_pkg::ROW_W'(1);
					end else begin
						c_q <= c_q + gmtd_pkg::COL_W'(1);
					end
					if (cnt_q == '0) begin
						best_found_q <= 1'b0;
					end
				end
				gmtd_pkg::DP_NWRITE: begin
					k_q <= k_q + 2'd1;
				end
				default: begin
					k_q <= k_q;
				end
			endcase
			if (scan_vld_s1 && node_rd_q.reached && !node_rd_q.visited &&
			    (!best_found_q || (node_rd_q.t_arr < best_dist_q))) begin
				best_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_idx_s1 <= cnt_q[AW-1:0];
		scan_r_s1   <= r_q;
		scan_c_s1   <= c_q;
		nbr_idx_s1  <= nbr_idx;
		if (scan_vld_s1 && node_rd_q.reached && !node_rd_q.visited &&
		    (!best_found_q || (node_rd_q.t_arr < best_dist_q))) begin
			best_idx_q  <= scan_idx_s1;
			best_r_q    <= scan_r_s1;
			best_c_q    <= scan_c_s1;
			best_dist_q <= node_rd_q.t_arr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (op == gmtd_pkg::DP_EMIT_OK || op == gmtd_pkg::DP_EMIT_UNR) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == gmtd_pkg::DP_EMIT_OK) begin
			out_time_q <= best_dist_q;
			out_unr_q  <= 1'b0;
		end else if (op == gmtd_pkg::DP_EMIT_UNR) begin
			out_time_q <= '0;
			out_unr_q  <= 1'b1;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign min_time    = out_time_q;
	assign unreachable = out_unr_q;

	assign sts.chk_block   = chk_a_q && (cell_rd_q > gmtd_pkg::TIME_BITS'(1));
	assign sts.clear_last  = cnt_q == target;
	assign sts.scan_last   = cnt_q == target;
	assign sts.pick_none   = !best_found_q;
	assign sts.pick_target = best_found_q && (CW'(best_idx_q) == target);
	assign sts.nbr_last    = k_q == 2'd3;
	assign sts.out_free    = !out_valid_q || rsp_ready;

endmodule

### rtl/gmtd_ctrl.sv
// Controller state machine that sequences loading, clearing, scanning and relaxation.
module gmtd_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	input  logic                  req_last,
	output logic                  req_ready,
	output gmtd_pkg::dp_op_t      op,
	input  gmtd_pkg::dp_sts_t     sts
);

	gmtd_pkg::ctrl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gmtd_pkg::S_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			gmtd_pkg::S_LOAD: begin
				if (req_valid && req_last) begin
					state_d = gmtd_pkg::S_CHK1;
				end
			end
			gmtd_pkg::S_CHK1:     state_d = gmtd_pkg::S_CHK2;
			gmtd_pkg::S_CHK2:     state_d = gmtd_pkg::S_CHK3;
			gmtd_pkg::S_CHK3: begin
				state_d = sts.chk_block ? gmtd_pkg::S_EMIT_UNR : gmtd_pkg::S_CLEAR;
			end
			gmtd_pkg::S_CLEAR: begin
				if (sts.clear_last) begin
					state_d = gmtd_pkg::S_START;
				end
			end
			gmtd_pkg::S_START:    state_d = gmtd_pkg::S_SCAN;
			gmtd_pkg::S_SCAN: begin
				if (sts.scan_last) begin
					state_d = gmtd_pkg::S_SCAN_END;
				end
			end
			gmtd_pkg::S_SCAN_END: state_d = gmtd_pkg::S_PICK;
			gmtd_pkg::S_PICK: begin
				if (sts.pick_none) begin
					state_d = gmtd_pkg::S_EMIT_UNR;
				end else if (sts.pick_target) begin
					state_d = gmtd_pkg::S_EMIT_OK;
				end else begin
					state_d = gmtd_pkg::S_NREAD;
				end
			end
			gmtd_pkg::S_NREAD:    state_d = gmtd_pkg::S_NWRITE;
			gmtd_pkg::S_NWRITE: begin
				state_d = sts.nbr_last ? gmtd_pkg::S_SCAN : gmtd_pkg::S_NREAD;
			end
			gmtd_pkg::S_EMIT_OK, gmtd_pkg::S_EMIT_UNR: begin
				if (sts.out_free) begin
					state_d = gmtd_pkg::S_LOAD;
				end
			end
			default:              state_d = gmtd_pkg::S_LOAD;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		op        = gmtd_pkg::DP_IDLE;
		case (state_q)
			gmtd_pkg::S_LOAD:     req_ready = 1'b1;
			gmtd_pkg::S_CHK1:     op = gmtd_pkg::DP_CHK1;
			gmtd_pkg::S_CHK2:     op = gmtd_pkg::DP_CHK2;
			gmtd_pkg::S_CLEAR:    op = gmtd_pkg::DP_CLEAR;
			gmtd_pkg::S_START:    op = gmtd_pkg::DP_START;
			gmtd_pkg::S_SCAN:     op = gmtd_pkg::DP_SCAN;
			gmtd_pkg::S_PICK: begin
				if (!sts.pick_none && !sts.pick_target) begin
					op = gmtd_pkg::DP_MARK;
				end
			end
			gmtd_pkg::S_NREAD:    op = gmtd_pkg::DP_NREAD;
			gmtd_pkg::S_NWRITE:   op = gmtd_pkg::DP_NWRITE;
			gmtd_pkg::S_EMIT_OK: begin
				if (sts.out_free) begin
					op = gmtd_pkg::DP_EMIT_OK;
				end
			end
			gmtd_pkg::S_EMIT_UNR: begin
				if (sts.out_free) begin
					op = gmtd_pkg::DP_EMIT_UNR;
				end
			end
			default:              op = gmtd_pkg::DP_IDLE;
		endcase
	end

`ifndef SYNTHESIS
	a_last_starts_check: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gmtd_pkg::S_LOAD && req_valid && req_last) |=> state_q == gmtd_pkg::S_CHK1)
		else $error("Last cell transfer did not start the search.");
	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(op == gmtd_pkg::DP_EMIT_OK || op == gmtd_pkg::DP_EMIT_UNR) |-> sts.out_free)
		else $error("Result loaded while the output register was still full.");
	a_nbr_back_to_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == gmtd_pkg::S_NWRITE && sts.nbr_last) |=> state_q == gmtd_pkg::S_SCAN)
		else $error("Neighbor relaxation did not return to the scan.");
`endif

endmodule

### rtl/grid_min_time_dijkstra_unit.sv
// Top level of the grid minimum-time search unit.
// Channel  | Dir | Payload                     | Transfer
// req      | in  | cell_time, last_cell        | valid && ready
// rsp      | out | min_time, unreachable       | valid && ready
// cfg      | in  | cfg_index, cfg_data         | cfg_we
// A cell without the last mark is stored and the unit stays ready for the next. A last cell
// starts a search that holds off further cells: three start-check steps, then one node-store
// clear pass over all rows*cols cells and one start step, then per settled cell a scan of all
// rows*cols nodes plus the relaxation of its four neighbors, each read and then written.
// Reset leaves the unit ready for cells; a full result register only delays the end of a search.
module grid_min_time_dijkstra_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [gmtd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gmtd_pkg::DIM_W-1:0]        cfg_data,
	gmtd_in_if.sink                           req,
	gmtd_out_if.source                        rsp
);

	gmtd_pkg::dp_op_t  op;
	gmtd_pkg::dp_sts_t sts;

	gmtd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_last  (req.last_cell),
		.req_ready (req.ready),
		.op        (op),
		.sts       (sts)
	);

	gmtd_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.load_en     (req.valid && req.ready),
		.cell_time   (req.cell_time),
		.last_cell   (req.last_cell),
		.op          (op),
		.sts         (sts),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.min_time    (rsp.min_time),
		.unreachable (rsp.unreachable)
	);

endmodule
